FILE: sv/segment_hole_merge_and_compact_defines.svh
// Assertion macros shared by the checker of the segment compaction block.
`ifndef SEGMENT_HOLE_MERGE_AND_COMPACT_DEFINES_SVH
`define SEGMENT_HOLE_MERGE_AND_COMPACT_DEFINES_SVH

// Property that is ignored while reset is high.
`define SHMC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property that is checked during reset as well.
`define SHMC_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/shmc_pkg.sv
`default_nettype none

package shmc_pkg;

   localparam int ADDR_BITS = 16;
   localparam int PID_BITS  = 8;

   localparam logic [ADDR_BITS-1:0] ADDR_MAX = {ADDR_BITS{1'b1}};

   // Both queues use power-of-two depths so that the pointers wrap on their own.
   localparam int CMD_DEPTH    = 4;
   localparam int CMD_PTR_BITS = $clog2(CMD_DEPTH);
   localparam int CMD_CNT_BITS = $clog2(CMD_DEPTH + 1);

   localparam int RSP_DEPTH    = 4;
   localparam int RSP_PTR_BITS = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_BITS = $clog2(RSP_DEPTH + 1);

   localparam int WR_CNT_BITS = 2;

   typedef struct packed {
      logic [PID_BITS-1:0]  pid;
      logic [ADDR_BITS-1:0] base;
      logic [ADDR_BITS-1:0] limit;
      logic                 allocated;
      logic                 last;
   } seg_type;

   // Up to two results written into the result queue in one cycle.
   typedef struct packed {
      logic [WR_CNT_BITS-1:0] count;
      seg_type                data0;
      seg_type                data1;
   } wr_type;

   function automatic logic [ADDR_BITS-1:0] sat_add(input logic [ADDR_BITS-1:0] a,
                                                    input logic [ADDR_BITS-1:0] b);
      logic [ADDR_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[ADDR_BITS] ? ADDR_MAX : s[ADDR_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

FILE: sv/shmc_front.sv
`default_nettype none

module shmc_front (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_push,
   output logic                                req_full,
   input  wire logic [shmc_pkg::PID_BITS-1:0]  req_seg_pid,
   input  wire logic [shmc_pkg::ADDR_BITS-1:0] req_seg_base,
   input  wire logic [shmc_pkg::ADDR_BITS-1:0] req_seg_limit,
   input  wire logic                           req_seg_allocated,
   input  wire logic                           req_seg_last,
   output logic                                cmd_valid,
   output shmc_pkg::seg_type                   cmd,
   input  wire logic                           cmd_pop
);

   shmc_pkg::seg_type                       mem_ff [shmc_pkg::CMD_DEPTH];
   logic [shmc_pkg::CMD_PTR_BITS-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [shmc_pkg::CMD_PTR_BITS-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [shmc_pkg::CMD_CNT_BITS-1:0]       count_ff, count_in;
   logic                                    push_ok;
   logic                                    pop_ok;
   shmc_pkg::seg_type                       entry;

   assign req_full  = (count_ff == shmc_pkg::CMD_CNT_BITS'(shmc_pkg::CMD_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd       = mem_ff[rd_ptr_ff];
   assign push_ok   = req_push && !req_full;
   assign pop_ok    = cmd_pop && cmd_valid;

   // Holes carry no process, so their pid is cleared on the way in.
   always_comb begin
      entry.pid       = req_seg_allocated ? req_seg_pid : '0;
      entry.base      = req_seg_base;
      entry.limit     = req_seg_limit;
      entry.allocated = req_seg_allocated;
      entry.last      = req_seg_last;
   end

   always_comb begin
      wr_ptr_in = push_ok ? shmc_pkg::CMD_PTR_BITS'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop_ok ? shmc_pkg::CMD_PTR_BITS'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = shmc_pkg::CMD_CNT_BITS'(count_ff
                  + shmc_pkg::CMD_CNT_BITS'(push_ok)
                  - shmc_pkg::CMD_CNT_BITS'(pop_ok));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule

`default_nettype wire

FILE: sv/shmc_back.sv
`default_nettype none

module shmc_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_we,
   input  wire logic              csr_wdata,
   input  wire logic              cmd_valid,
   input  wire shmc_pkg::seg_type cmd,
   output logic                   cmd_pop,
   input  wire logic              rsp_room,
   output shmc_pkg::wr_type       rsp_wr
);

   logic                            compact_ff;
   logic                            first_ff, first_in;
   logic                            held_valid_ff, held_valid_in;
   shmc_pkg::seg_type               held_ff, held_in;
   logic [shmc_pkg::ADDR_BITS-1:0]  running_ff, running_in;
   logic [shmc_pkg::ADDR_BITS-1:0]  free_ff, free_in;
   logic                            fire;

   assign fire    = cmd_valid && rsp_room;
   assign cmd_pop = fire;

   always_comb begin
      logic [shmc_pkg::ADDR_BITS-1:0] run_eff;
      logic [shmc_pkg::ADDR_BITS-1:0] free_eff;
      logic                           hv_eff;
      shmc_pkg::seg_type              r0;
      shmc_pkg::seg_type              r1;
      logic                           v0;
      logic                           v1;

      first_in      = first_ff;
      held_valid_in = held_valid_ff;
      held_in       = held_ff;
      running_in    = running_ff;
      free_in       = free_ff;
      r0            = held_ff;
      r1            = held_ff;
      v0            = 1'b0;
      v1            = 1'b0;

      // The first segment of a map sets the base that everything is packed from.
      run_eff  = first_ff ? cmd.base : running_ff;
      free_eff = first_ff ? '0 : free_ff;
      hv_eff   = first_ff ? 1'b0 : held_valid_ff;

      if (fire) begin
         first_in      = 1'b0;
         held_valid_in = hv_eff;
         running_in    = run_eff;
         free_in       = free_eff;
         if (!compact_ff) begin
            if (hv_eff && !held_ff.allocated && !cmd.allocated) begin
               held_in.limit = shmc_pkg::sat_add(held_ff.limit, cmd.limit);
            end else begin
               if (hv_eff) begin
                  v0         = 1'b1;
                  r0         = held_ff;
                  r0.last    = 1'b0;
                  running_in = shmc_pkg::sat_add(held_ff.base, held_ff.limit);
               end
               held_valid_in     = 1'b1;
               held_in.pid       = cmd.pid;
               held_in.base      = running_in;
               held_in.limit     = cmd.limit;
               held_in.allocated = cmd.allocated;
               held_in.last      = 1'b0;
            end
            if (cmd.last) begin
               v1      = 1'b1;
               r1      = held_in;
               r1.last = 1'b1;
            end
         end else begin
            if (cmd.allocated) begin
               v0           = 1'b1;
               r0.pid       = cmd.pid;
               r0.base      = run_eff;
               r0.limit     = cmd.limit;
               r0.allocated = 1'b1;
               r0.last      = cmd.last && (free_eff == '0);
               running_in   = shmc_pkg::sat_add(run_eff, cmd.limit);
            end else begin
               free_in = shmc_pkg::sat_add(free_eff, cmd.limit);
            end
            // A map that ends on a hole always gets a trailing hole, even of length zero.
            if (cmd.last && ((free_in != '0) || !cmd.allocated)) begin
               v1           = 1'b1;
               r1.pid       = '0;
               r1.base      = running_in;
               r1.limit     = free_in;
               r1.allocated = 1'b0;
               r1.last      = 1'b1;
            end
         end
         if (cmd.last) begin
            first_in      = 1'b1;
            held_valid_in = 1'b0;
            held_in       = '0;
            running_in    = '0;
            free_in       = '0;
         end
      end

      // A register write abandons whatever map was in progress.
      if (csr_we) begin
         first_in      = 1'b1;
         held_valid_in = 1'b0;
         held_in       = '0;
         running_in    = '0;
         free_in       = '0;
      end

      rsp_wr.count = {1'b0, v0} + {1'b0, v1};
      rsp_wr.data0 = v0 ? r0 : r1;
      rsp_wr.data1 = r1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         compact_ff    <= 1'b0;
         first_ff      <= 1'b1;
         held_valid_ff <= 1'b0;
         held_ff       <= '0;
         running_ff    <= '0;
         free_ff       <= '0;
      end else begin
         if (csr_we) begin
            compact_ff <= csr_wdata;
         end
         first_ff      <= first_in;
         held_valid_ff <= held_valid_in;
         held_ff       <= held_in;
         running_ff    <= running_in;
         free_ff       <= free_in;
      end
   end

endmodule

`default_nettype wire

FILE: sv/shmc_rsp_queue.sv
`default_nettype none

module shmc_rsp_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire shmc_pkg::wr_type rsp_wr,
   output logic                  rsp_room,
   output logic                  rsp_empty,
   input  wire logic             rsp_pop,
   output shmc_pkg::seg_type     head
);

   shmc_pkg::seg_type                  mem_ff [shmc_pkg::RSP_DEPTH];
   logic [shmc_pkg::RSP_PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [shmc_pkg::RSP_PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [shmc_pkg::RSP_CNT_BITS-1:0]  count_ff, count_in;
   logic [shmc_pkg::RSP_PTR_BITS-1:0]  wr_ptr_next;
   logic                               pop_ok;

   // Room means a worst-case item, which leaves two results, still fits.
   assign rsp_room    = (count_ff <= shmc_pkg::RSP_CNT_BITS'(shmc_pkg::RSP_DEPTH - 2));
   assign rsp_empty   = (count_ff == '0);
   assign head        = mem_ff[rd_ptr_ff];
   assign pop_ok      = rsp_pop && !rsp_empty;
   assign wr_ptr_next = shmc_pkg::RSP_PTR_BITS'(wr_ptr_ff + 1'b1);

   always_comb begin
      wr_ptr_in = shmc_pkg::RSP_PTR_BITS'(wr_ptr_ff
                  + shmc_pkg::RSP_PTR_BITS'(rsp_wr.count));
      rd_ptr_in = pop_ok ? shmc_pkg::RSP_PTR_BITS'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = shmc_pkg::RSP_CNT_BITS'(count_ff
                  + shmc_pkg::RSP_CNT_BITS'(rsp_wr.count)
                  - shmc_pkg::RSP_CNT_BITS'(pop_ok));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_wr.count != '0) begin
         mem_ff[wr_ptr_ff] <= rsp_wr.data0;
      end
      if (rsp_wr.count == shmc_pkg::WR_CNT_BITS'(2)) begin
         mem_ff[wr_ptr_next] <= rsp_wr.data1;
      end
   end

endmodule

`default_nettype wire

FILE: sv/segment_hole_merge_and_compact.sv
// Segment hole merge and compaction over a streamed memory map.
// Input channel: segments are pushed with req_push while req_full is low, one
// map after another, the final segment of each map flagged by req_seg_last.
// Result channel: rebased segments are read while rsp_empty is low; rsp_pop
// takes the one on the ports. Each segment yields zero, one or two results.
// Configuration: csr_we writes csr_wdata into the compaction mode bit
// (0 merges adjacent holes, 1 packs processes and gathers free space into at most one trailing hole).
// A write also drops any partly received map.
// A transferred segment is registered in the segment queue, processed
// combinationally, and its results are registered in the result queue. In
// merge mode a segment is held back until the following segment of the map
// shows whether a hole run goes on, so it leaves together with that segment's
// results. Throughput is one segment per cycle while the result queue has room;
// a segment that yields two results takes two pops to drain.
// A four-entry segment queue sits in front of the processing stage and a
// four-entry result queue behind it. When the receiver stalls, the result
// queue fills, the processing stage waits, and req_full rises once the
// segment queue is full as well; nothing is lost.
// Reset clears both queues, the mode bit and all map state.
`default_nettype none

module segment_hole_merge_and_compact (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_push,
   output logic                                req_full,
   input  wire logic [shmc_pkg::PID_BITS-1:0]  req_seg_pid,
   input  wire logic [shmc_pkg::ADDR_BITS-1:0] req_seg_base,
   input  wire logic [shmc_pkg::ADDR_BITS-1:0] req_seg_limit,
   input  wire logic                           req_seg_allocated,
   input  wire logic                           req_seg_last,
   output logic                                rsp_empty,
   input  wire logic                           rsp_pop,
   output logic [shmc_pkg::PID_BITS-1:0]       rsp_out_pid,
   output logic [shmc_pkg::ADDR_BITS-1:0]      rsp_out_base,
   output logic [shmc_pkg::ADDR_BITS-1:0]      rsp_out_limit,
   output logic                                rsp_out_allocated,
   output logic                                rsp_out_last,
   input  wire logic                           csr_we,
   input  wire logic                           csr_wdata
);

   logic               cmd_valid;
   logic               cmd_pop;
   shmc_pkg::seg_type  cmd;
   logic               rsp_room;
   shmc_pkg::wr_type   rsp_wr;
   shmc_pkg::seg_type  head;

   shmc_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_seg_pid       (req_seg_pid),
      .req_seg_base      (req_seg_base),
      .req_seg_limit     (req_seg_limit),
      .req_seg_allocated (req_seg_allocated),
      .req_seg_last      (req_seg_last),
      .cmd_valid         (cmd_valid),
      .cmd               (cmd),
      .cmd_pop           (cmd_pop)
   );

   shmc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_room  (rsp_room),
      .rsp_wr    (rsp_wr)
   );

   shmc_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .rsp_wr    (rsp_wr),
      .rsp_room  (rsp_room),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .head      (head)
   );

   assign rsp_out_pid       = head.pid;
   assign rsp_out_base      = head.base;
   assign rsp_out_limit     = head.limit;
   assign rsp_out_allocated = head.allocated;
   assign rsp_out_last      = head.last;

endmodule

`default_nettype wire

FILE: sv/shmc_checker.sv
`default_nettype none
`include "segment_hole_merge_and_compact_defines.svh"

module shmc_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_push,
   input wire logic                           req_full,
   input wire logic                           rsp_empty,
   input wire logic                           rsp_pop,
   input wire logic [shmc_pkg::PID_BITS-1:0]  rsp_out_pid,
   input wire logic [shmc_pkg::ADDR_BITS-1:0] rsp_out_base,
   input wire logic [shmc_pkg::ADDR_BITS-1:0] rsp_out_limit,
   input wire logic                           rsp_out_allocated,
   input wire logic                           rsp_out_last
);

   // Reset leaves both queues empty.
   `SHMC_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> (rsp_empty && !req_full), "queues not empty after reset")

   // Right after reset, no result appears unless a segment has been transferred.
   `SHMC_ASSERT_ALWAYS(a_no_early_result, clock, (reset ##1 !(req_push && !req_full)) |=> rsp_empty, "result appeared with no segment in flight")

   // A waiting result holds until it is popped.
   `SHMC_ASSERT(a_rsp_hold, clock, reset, (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_out_pid) && $stable(rsp_out_base) && $stable(rsp_out_limit) && $stable(rsp_out_allocated) && $stable(rsp_out_last)), "stalled result changed")

   // A hole never carries a process id, whatever the mode.
   `SHMC_ASSERT(a_hole_pid, clock, reset, (!rsp_empty && !rsp_out_allocated) |-> (rsp_out_pid == '0), "hole result with nonzero pid")

endmodule

bind segment_hole_merge_and_compact shmc_checker u_shmc_checker (.*);

`default_nettype wire
